// ===== sv/cfus_pkg.sv =====
`default_nettype none
package cfus_pkg;

  localparam int ADDR_W      = 32;
  localparam int TLEN_W      = 24;
  localparam int CLEN_W      = 13;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;

  // Largest byte count that command_length can carry
  localparam int LEN_FIELD_MAX = 8191;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_READING   = 4'b0010,
    PH_READ      = 4'b0100,
    PH_UPLOADING = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_UPLOAD = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  target_address;
    logic [TLEN_W-1:0]  total_length;
    logic               flash_done;
    logic               upload_done;
  } item_t;

  typedef struct packed {
    logic               busy_res;
    cmd_t               command;
    logic [ADDR_W-1:0]  command_address;
    logic [CLEN_W-1:0]  command_length;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/cfus_core.sv =====
`default_nettype none
module cfus_core #(
  parameter int CHUNK_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  cfus_pkg::item_t   item,
  output cfus_pkg::result_t res
);

  localparam int EFF_CHUNK = (CHUNK_SIZE > cfus_pkg::LEN_FIELD_MAX) ?
                             cfus_pkg::LEN_FIELD_MAX : CHUNK_SIZE;
  localparam logic [cfus_pkg::CLEN_W-1:0] EFF_LEN = cfus_pkg::CLEN_W'(EFF_CHUNK);

  logic                            active_r, active_nxt;
  cfus_pkg::phase_t                phase_r, phase_nxt;
  logic [cfus_pkg::TLEN_W-1:0]     issued_r, issued_nxt;
  logic [cfus_pkg::TLEN_W-1:0]     offset_r, offset_nxt;
  logic [cfus_pkg::CLEN_W-1:0]     clen_r, clen_nxt;
  logic [cfus_pkg::ADDR_W-1:0]     src_r, src_nxt;
  logic [cfus_pkg::ADDR_W-1:0]     tgt_r, tgt_nxt;
  logic [cfus_pkg::TLEN_W-1:0]     total_r, total_nxt;

  logic [cfus_pkg::TLEN_W-1:0]     remain;
  logic [cfus_pkg::CLEN_W-1:0]     chunk_len;

  assign remain    = total_r - issued_r;
  assign chunk_len = (remain > {{(cfus_pkg::TLEN_W-cfus_pkg::CLEN_W){1'b0}}, EFF_LEN}) ?
                     EFF_LEN : remain[cfus_pkg::CLEN_W-1:0];

  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    issued_nxt = issued_r;
    offset_nxt = offset_r;
    clen_nxt   = clen_r;
    src_nxt    = src_r;
    tgt_nxt    = tgt_r;
    total_nxt  = total_r;
    res        = '{busy_res: 1'b1, command: cfus_pkg::CMD_NONE,
                   command_address: '0, command_length: '0};
    priority if (item.operation == cfus_pkg::OP_START) begin
      // load a new transfer, abandon any running one
      src_nxt    = item.source_address;
      tgt_nxt    = item.target_address;
      total_nxt  = item.total_length;
      issued_nxt = '0;
      offset_nxt = '0;
      clen_nxt   = '0;
      phase_nxt  = cfus_pkg::PH_IDLE;
      active_nxt = 1'b1;
    end else if (!active_r) begin
      res.busy_res = 1'b0;
    end else begin
      unique case (phase_r)
        cfus_pkg::PH_IDLE: begin
          if (issued_r >= total_r) begin
            active_nxt  = 1'b0;
            res.command = cfus_pkg::CMD_FINISH;
          end else begin
            offset_nxt          = issued_r;
            clen_nxt            = chunk_len;
            issued_nxt          = issued_r + {{(cfus_pkg::TLEN_W-cfus_pkg::CLEN_W){1'b0}},
                                              chunk_len};
            phase_nxt           = cfus_pkg::PH_READING;
            res.command         = cfus_pkg::CMD_READ;
            res.command_address = src_r + {{(cfus_pkg::ADDR_W-cfus_pkg::TLEN_W){1'b0}},
                                           issued_r};
            res.command_length  = chunk_len;
          end
        end
        cfus_pkg::PH_READING: begin
          if (item.flash_done) phase_nxt = cfus_pkg::PH_READ;
        end
        cfus_pkg::PH_READ: begin
          phase_nxt           = cfus_pkg::PH_UPLOADING;
          res.command         = cfus_pkg::CMD_UPLOAD;
          res.command_address = tgt_r + {{(cfus_pkg::ADDR_W-cfus_pkg::TLEN_W){1'b0}},
                                         offset_r};
          res.command_length  = clen_r;
        end
        cfus_pkg::PH_UPLOADING: begin
          if (item.upload_done) phase_nxt = cfus_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = cfus_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= cfus_pkg::PH_IDLE;
      issued_r <= '0;
      offset_r <= '0;
      clen_r   <= '0;
      src_r    <= '0;
      tgt_r    <= '0;
      total_r  <= '0;
    end else if (step_en) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      issued_r <= issued_nxt;
      offset_r <= offset_nxt;
      clen_r   <= clen_nxt;
      src_r    <= src_nxt;
      tgt_r    <= tgt_nxt;
      total_r  <= total_nxt;
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    issued_r <= total_r)
    else $error("issued position ran past the transfer length");

  a_finish_drops: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.command == cfus_pkg::CMD_FINISH |=> !active_r)
    else $error("transfer still active after finish");

  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.command == cfus_pkg::CMD_READ |->
      res.command_length != '0 && res.command_length <= EFF_LEN)
    else $error("read chunk length out of range");

  a_upload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.command == cfus_pkg::CMD_UPLOAD |=> phase_r == cfus_pkg::PH_UPLOADING)
    else $error("upload issued without entering upload wait");

endmodule
`default_nettype wire

// ===== sv/chunked_flash_upload_sequencer.sv =====
// Path: a request accepted into the input register reaches out_tdata through the
// result register. Throughput: one request per cycle while the result register is
// free or draining; the input register and the result register advance together,
// so the sequencer state takes one step per request.
// Reset: rst_n is synchronous, active low; it empties both registers and returns
// the sequencer to inactive with the buffer idle and all positions at zero.
`default_nettype none
module chunked_flash_upload_sequencer #(
  parameter int CHUNK_SIZE = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] source_address, [63:32] target_address, [87:64] total_length,
  // [88] flash_done, [89] upload_done, [95:90] zero
  input  logic [cfus_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] busy_res, [32:1] command_address, [45:33] command_length, [47:46] zero
  output logic [cfus_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] command
  output logic [1:0]                          out_tuser
);

  // Input register: holds the request until the result register has room
  logic              in_valid_r;
  cfus_pkg::item_t   in_item_r, in_item_nxt;
  logic              step;

  // Result register
  logic              out_valid_r;
  cfus_pkg::result_t out_res_r;
  cfus_pkg::result_t res;

  // Advance when a request is held and the result slot is free or draining
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  // Unpack the stream word into the request fields
  always_comb begin
    in_item_nxt.operation      = cfus_pkg::op_t'(in_tuser[0]);
    in_item_nxt.source_address = in_tdata[31:0];
    in_item_nxt.target_address = in_tdata[63:32];
    in_item_nxt.total_length   = in_tdata[87:64];
    in_item_nxt.flash_done     = in_tdata[88];
    in_item_nxt.upload_done    = in_tdata[89];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item_nxt;
    end
  end

  // Sequencer state and the step logic; state moves only when the request advances
  cfus_core #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (in_item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  // Pack the result; the spare top bits stay zero
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.command_length, out_res_r.command_address,
                       out_res_r.busy_res};
  assign out_tuser  = out_res_r.command;

endmodule
`default_nettype wire
